// ===== rtl/core/imhq_pkg.sv =====
`timescale 1ns / 1ps
package imhq_pkg;

	localparam int KEY_BITS       = 6;
	localparam int KEY_SPACE      = 64;
	localparam int RES_VAL_BITS   = 32;
	localparam int COUNT_OUT_BITS = 7;
	localparam int OUT_W          = 48;
	localparam int DEF_CAPACITY   = 64;
	localparam int DEF_VALUE_BITS = 32;

	typedef enum logic [1:0] {
		CMD_PUSH,
		CMD_POP,
		CMD_DECREASE,
		CMD_PEEK
	} cmd_t;

	typedef enum logic [2:0] {
		STAT_OK,
		STAT_FULL,
		STAT_EMPTY,
		STAT_PRESENT,
		STAT_ABSENT,
		STAT_NOT_SMALLER
	} status_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DECODE,
		S_POP,
		S_DEC_RD,
		S_DEC_CMP,
		S_UP_RD,
		S_UP_CMP,
		S_DN_RD,
		S_DN_CMP,
		S_ROOT,
		S_RESULT
	} state_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PUSH_INIT,
		OP_POP_RD,
		OP_POP_INIT,
		OP_POS_RD,
		OP_DEC_RD,
		OP_DEC_INIT,
		OP_UP_RD,
		OP_UP_STEP,
		OP_DN_RD,
		OP_DN_STEP,
		OP_PLACE,
		OP_ROOT_RD,
		OP_RESULT
	} op_t;

	typedef struct packed {
		op_t     op;
		logic    st_we;
		status_t st;
	} ctrl_t;

	typedef struct packed {
		cmd_t cmd;
		logic present;
		logic empty;
		logic full;
		logic pos_bad;
		logic dec_less;
		logic up_root;
		logic up_swap;
		logic dn_leaf;
		logic dn_swap;
	} stat_t;

endpackage

// ===== rtl/core/imhq_datapath.sv =====
`timescale 1ns / 1ps
module imhq_datapath #(
	parameter int CAPACITY   = imhq_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = imhq_pkg::DEF_VALUE_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  imhq_pkg::ctrl_t                   ctrl,
	output imhq_pkg::stat_t                   stat,
	input  imhq_pkg::cmd_t                    cmd_in,
	input  logic [imhq_pkg::KEY_BITS-1:0]     key_in,
	input  logic signed [VALUE_BITS-1:0]      val_in,
	output logic [imhq_pkg::OUT_W-1:0]        out_data,
	output imhq_pkg::status_t                 out_status
);
	import imhq_pkg::*;

	localparam int PW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int XW = PW + 2;

	logic [KEY_BITS-1:0]          key_mem [CAPACITY];
	logic signed [VALUE_BITS-1:0] val_mem [CAPACITY];
	logic [PW-1:0]                pos_mem [KEY_SPACE];

	cmd_t                    cmd_q;
	logic [KEY_BITS-1:0]     key_q, cur_key_q, pop_key_q, rd_a_key_q, rd_b_key_q;
	logic signed [VALUE_BITS-1:0] val_q, cur_val_q, pop_val_q, rd_a_val_q, rd_b_val_q;
	logic [PW-1:0]           p_q, pos_rd_q;
	logic [CW-1:0]           cnt_q;
	logic [KEY_SPACE-1:0]    present_q;
	logic                    popped_q;
	status_t                 status_q;

	logic [PW-1:0]           p_dec, parent, last_idx, child_idx, addr_a, addr_b;
	logic [CW-1:0]           cnt_dec;
	logic [XW-1:0]           left_x, right_x, cnt_x;
	logic                    r_ok, take_r, rd_en, we;
	logic [KEY_BITS-1:0]     child_key, wkey, res_key;
	logic signed [VALUE_BITS-1:0] child_val, wval, res_val;
	logic [VALUE_BITS+RES_VAL_BITS-1:0] val_x;
	logic [CW+COUNT_OUT_BITS-1:0] cnt_ox;

	assign p_dec     = p_q - PW'(1);
	assign parent    = p_dec >> 1;
	assign cnt_dec   = cnt_q - CW'(1);
	assign last_idx  = cnt_dec[PW-1:0];
	assign left_x    = {1'b0, p_q, 1'b1};
	assign right_x   = left_x + XW'(1);
	assign cnt_x     = XW'(cnt_q);
	assign r_ok      = right_x < cnt_x;
	assign take_r    = r_ok && (rd_b_val_q < rd_a_val_q);
	assign child_key = take_r ? rd_b_key_q : rd_a_key_q;
	assign child_val = take_r ? rd_b_val_q : rd_a_val_q;
	assign child_idx = take_r ? right_x[PW-1:0] : left_x[PW-1:0];

	always_comb begin
		stat.cmd      = cmd_q;
		stat.present  = present_q[key_q];
		stat.empty    = cnt_q == '0;
		stat.full     = cnt_q == CW'(CAPACITY);
		stat.pos_bad  = XW'(pos_rd_q) >= cnt_x;
		stat.dec_less = val_q < rd_a_val_q;
		stat.up_root  = p_q == '0;
		stat.up_swap  = cur_val_q < rd_a_val_q;
		stat.dn_leaf  = !(left_x < cnt_x);
		stat.dn_swap  = child_val < cur_val_q;
	end

	always_comb begin
		rd_en  = 1'b0;
		addr_a = '0;
		addr_b = '0;
		case (ctrl.op)
			OP_POP_RD: begin
				rd_en  = 1'b1;
				addr_b = last_idx;
			end
			OP_UP_RD: begin
				rd_en  = 1'b1;
				addr_a = parent;
			end
			OP_DN_RD: begin
				rd_en  = 1'b1;
				addr_a = left_x[PW-1:0];
				addr_b = right_x[PW-1:0];
			end
			OP_DEC_RD: begin
				rd_en  = 1'b1;
				addr_a = pos_rd_q;
			end
			OP_ROOT_RD: begin
				rd_en = 1'b1;
			end
			default: begin
				rd_en = 1'b0;
			end
		endcase
	end

	always_comb begin
		we   = 1'b0;
		wkey = cur_key_q;
		wval = cur_val_q;
		case (ctrl.op)
			OP_UP_STEP: begin
				we   = 1'b1;
				wkey = rd_a_key_q;
				wval = rd_a_val_q;
			end
			OP_DN_STEP: begin
				we   = 1'b1;
				wkey = child_key;
				wval = child_val;
			end
			OP_PLACE: begin
				we = 1'b1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	// heap slots and key index
	always_ff @(posedge clk) begin
		if (we) begin
			key_mem[p_q]  <= wkey;
			val_mem[p_q]  <= wval;
			pos_mem[wkey] <= p_q;
		end
		if (rd_en) begin
			rd_a_key_q <= key_mem[addr_a];
			rd_a_val_q <= val_mem[addr_a];
			rd_b_key_q <= key_mem[addr_b];
			rd_b_val_q <= val_mem[addr_b];
		end
		if (ctrl.op == OP_POS_RD) begin
			pos_rd_q <= pos_mem[key_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q     <= '0;
			present_q <= '0;
			popped_q  <= 1'b0;
			status_q  <= STAT_OK;
			p_q       <= '0;
			cmd_q     <= CMD_PUSH;
		end else begin
			if (ctrl.st_we) begin
				status_q <= ctrl.st;
			end
			case (ctrl.op)
				OP_LOAD: begin
					cmd_q    <= cmd_in;
					popped_q <= 1'b0;
					status_q <= STAT_OK;
				end
				OP_PUSH_INIT: begin
					p_q               <= cnt_q[PW-1:0];
					cnt_q             <= cnt_q + CW'(1);
					present_q[key_q]  <= 1'b1;
				end
				OP_POP_INIT: begin
					popped_q              <= 1'b1;
					present_q[rd_a_key_q] <= 1'b0;
					cnt_q                 <= cnt_dec;
					p_q                   <= '0;
				end
				OP_DEC_RD: begin
					p_q <= pos_rd_q;
				end
				OP_UP_STEP: begin
					p_q <= parent;
				end
				OP_DN_STEP: begin
					p_q <= child_idx;
				end
				default: begin
					p_q <= p_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (ctrl.op)
			OP_LOAD: begin
				key_q <= key_in;
				val_q <= val_in;
			end
			OP_PUSH_INIT, OP_DEC_INIT: begin
				cur_key_q <= key_q;
				cur_val_q <= val_q;
			end
			OP_POP_INIT: begin
				pop_key_q <= rd_a_key_q;
				pop_val_q <= rd_a_val_q;
				cur_key_q <= rd_b_key_q;
				cur_val_q <= rd_b_val_q;
			end
			default: begin
				cur_key_q <= cur_key_q;
			end
		endcase
	end

	always_comb begin
		if (popped_q) begin
			res_key = pop_key_q;
			res_val = pop_val_q;
		end else if (cnt_q != '0) begin
			res_key = rd_a_key_q;
			res_val = rd_a_val_q;
		end else begin
			res_key = '0;
			res_val = '0;
		end
	end

	assign val_x  = {{RES_VAL_BITS{1'b0}}, $unsigned(res_val)};
	assign cnt_ox = {{COUNT_OUT_BITS{1'b0}}, cnt_q};

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.op == OP_RESULT) begin
			out_status <= status_q;
			out_data   <= {2'b00, cnt_ox[COUNT_OUT_BITS-1:0], cnt_q == '0,
				val_x[RES_VAL_BITS-1:0], res_key};
		end
	end

endmodule

// ===== rtl/core/imhq_ctrl.sv =====
`timescale 1ns / 1ps
module imhq_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            s_tvalid,
	output logic            s_tready,
	output logic            m_tvalid,
	input  logic            m_tready,
	input  imhq_pkg::stat_t stat,
	output imhq_pkg::ctrl_t ctrl
);
	import imhq_pkg::*;

	state_t state_q, state_d;
	logic   out_valid_q, out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = state_q == S_IDLE;
	assign m_tvalid = out_valid_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) state_d = S_DECODE;
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_PUSH: begin
						state_d = (stat.present || stat.full) ? S_ROOT : S_UP_RD;
					end
					CMD_POP: begin
						state_d = stat.empty ? S_ROOT : S_POP;
					end
					CMD_DECREASE: begin
						state_d = stat.present ? S_DEC_RD : S_ROOT;
					end
					default: begin
						state_d = S_ROOT;
					end
				endcase
			end
			S_POP:     state_d = S_DN_RD;
			S_DEC_RD:  state_d = stat.pos_bad ? S_ROOT : S_DEC_CMP;
			S_DEC_CMP: state_d = stat.dec_less ? S_UP_RD : S_ROOT;
			S_UP_RD:   state_d = stat.up_root ? S_ROOT : S_UP_CMP;
			S_UP_CMP:  state_d = stat.up_swap ? S_UP_RD : S_ROOT;
			S_DN_RD:   state_d = stat.dn_leaf ? S_ROOT : S_DN_CMP;
			S_DN_CMP:  state_d = stat.dn_swap ? S_DN_RD : S_ROOT;
			S_ROOT:    state_d = S_RESULT;
			S_RESULT: begin
				if (out_free) state_d = S_IDLE;
			end
			default:   state_d = S_IDLE;
		endcase
	end

	always_comb begin
		ctrl.op    = OP_NONE;
		ctrl.st_we = 1'b0;
		ctrl.st    = STAT_OK;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) ctrl.op = OP_LOAD;
			end
			S_DECODE: begin
				case (stat.cmd)
					CMD_PUSH: begin
						if (stat.present) begin
							ctrl.st_we = 1'b1;
							ctrl.st    = STAT_PRESENT;
						end else if (stat.full) begin
							ctrl.st_we = 1'b1;
							ctrl.st    = STAT_FULL;
						end else begin
							ctrl.op = OP_PUSH_INIT;
						end
					end
					CMD_POP: begin
						if (stat.empty) begin
							ctrl.st_we = 1'b1;
							ctrl.st    = STAT_EMPTY;
						end else begin
							ctrl.op = OP_POP_RD;
						end
					end
					CMD_DECREASE: begin
						if (stat.present) begin
							ctrl.op = OP_POS_RD;
						end else begin
							ctrl.st_we = 1'b1;
							ctrl.st    = STAT_ABSENT;
						end
					end
					default: begin
						if (stat.empty) begin
							ctrl.st_we = 1'b1;
							ctrl.st    = STAT_EMPTY;
						end
					end
				endcase
			end
			S_POP: ctrl.op = OP_POP_INIT;
			S_DEC_RD: begin
				if (stat.pos_bad) begin
					ctrl.st_we = 1'b1;
					ctrl.st    = STAT_ABSENT;
				end else begin
					ctrl.op = OP_DEC_RD;
				end
			end
			S_DEC_CMP: begin
				if (stat.dec_less) begin
					ctrl.op = OP_DEC_INIT;
				end else begin
					ctrl.st_we = 1'b1;
					ctrl.st    = STAT_NOT_SMALLER;
				end
			end
			S_UP_RD:  ctrl.op = stat.up_root ? OP_PLACE : OP_UP_RD;
			S_UP_CMP: ctrl.op = stat.up_swap ? OP_UP_STEP : OP_PLACE;
			S_DN_RD:  ctrl.op = stat.dn_leaf ? OP_PLACE : OP_DN_RD;
			S_DN_CMP: ctrl.op = stat.dn_swap ? OP_DN_STEP : OP_PLACE;
			S_ROOT:   ctrl.op = OP_ROOT_RD;
			S_RESULT: begin
				if (out_free) ctrl.op = OP_RESULT;
			end
			default: ctrl.op = OP_NONE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_RESULT && out_free) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

// ===== rtl/core/indexed_min_heap_queue_core.sv =====
`timescale 1ns / 1ps
// a request is loaded and decoded, a push, pop or decrease that changes the heap then
// sifts an entry, and the root is read before the result is registered; one request at
// a time, the next one is taken the cycle after its result is registered, also while
// that result waits
// each sift level is a heap memory read state then a compare and write state
// reset clears the count and the key presence flags at once, no clearing pass
module indexed_min_heap_queue_core #(
	parameter int CAPACITY   = imhq_pkg::DEF_CAPACITY,
	parameter int VALUE_BITS = imhq_pkg::DEF_VALUE_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	// entry_key, entry_value
	input  logic [((imhq_pkg::KEY_BITS+VALUE_BITS+7)/8)*8-1:0] s_tdata,
	// command
	input  logic [1:0] s_tuser,
	output logic m_tvalid,
	input  logic m_tready,
	// result_key, result_value, is_empty, entry_count
	output logic [imhq_pkg::OUT_W-1:0] m_tdata,
	// status
	output logic [2:0] m_tuser
);
	import imhq_pkg::*;

	ctrl_t   ctrl;
	stat_t   stat;
	status_t out_status;

	imhq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.ctrl     (ctrl)
	);

	imhq_datapath #(
		.CAPACITY   (CAPACITY),
		.VALUE_BITS (VALUE_BITS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.ctrl       (ctrl),
		.stat       (stat),
		.cmd_in     (cmd_t'(s_tuser)),
		.key_in     (s_tdata[KEY_BITS-1:0]),
		.val_in     (s_tdata[KEY_BITS +: VALUE_BITS]),
		.out_data   (m_tdata),
		.out_status (out_status)
	);

	assign m_tuser = out_status;

endmodule
